FILE: rtl/core/buddy_page_allocator_assert.svh
// Assertion macros for the buddy page allocator.
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define BPA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define BPA_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define BPA_ASSERT(lbl, prop, msg)
`define BPA_NEVER(lbl, cond, msg)
`endif
`endif

FILE: rtl/core/bpa_pkg.sv
package bpa_pkg;
	localparam int NUM_PAGES_C   = 4096;
	localparam int ORDER_COUNT_C = 11;
	localparam int PAGE_W        = 12;
	localparam int LINK_W        = 13;
	localparam int CNT_W         = 13;
	localparam int ORD_W         = 4;

	typedef logic [PAGE_W-1:0] page_t;
	typedef logic [LINK_W-1:0] link_t;
	typedef logic [ORD_W-1:0]  ord_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	localparam link_t NIL_LINK = link_t'(NUM_PAGES_C);
	localparam ord_t  TOP_ORD  = ord_t'(ORDER_COUNT_C - 1);
	localparam cnt_t  MAX_CNT  = cnt_t'(NUM_PAGES_C);

	// Request codes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Pair bits of all orders packed into one store: order o starts where
	// the orders below it end.
	function automatic page_t pair_addr(input ord_t o, input page_t pg);
		logic [PAGE_W:0] full;
		logic [PAGE_W:0] offs;
		page_t           idx;
		full = (PAGE_W+1)'(NUM_PAGES_C);
		offs = full - (full >> o);
		idx  = pg >> (o + ord_t'(1));
		return page_t'(offs) + idx;
	endfunction
endpackage

FILE: rtl/core/buddy_page_allocator.sv
// Buddy page allocator over 4096 pages, orders 0 to 10; one request worked at a time.
// An order above 10 goes straight to the result as a failure. A free merges upward
// through S_F_STEP and S_F_PAIR while the buddy's pair bit is set (never from the top
// order), then pushes the block in S_PUSH_A and S_PUSH_B; an allocate searches, unlinks
// and splits down to the requested order. Link and pair-bit memory reads are registered.
// Reset: lists empty, count zero; an S_CLEAR pass clears all 4096 pair bits, in_ready low.
`include "buddy_page_allocator_assert.svh"
module buddy_page_allocator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                op,
	input  bpa_pkg::ord_t       block_order,
	input  bpa_pkg::page_t      page_index,
	output logic                out_valid,
	input  logic                out_ready,
	output bpa_pkg::page_t      result_page,
	output logic                failed,
	output bpa_pkg::cnt_t       free_total
);
	import bpa_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_F_STEP, S_F_PAIR, S_UNL_APPLY, S_A_SRCH,
		S_A_TGL, S_A_TGLW, S_A_SPLIT, S_PUSH_A, S_PUSH_B, S_DONE
	} state_t;

	state_t state_q;
	page_t  clr_q;
	logic   op_q;
	ord_t   ord_q;      // requested order
	ord_t   cur_q;      // order being worked
	page_t  pg_q;
	page_t  upg_q;      // block being unlinked
	link_t  hd_q;       // old list head during a push
	logic   split_q;
	logic   fail_q;
	cnt_t   cnt_q;
	link_t  head_q [ORDER_COUNT_C];
	logic   out_valid_q;
	page_t  res_q;
	logic   res_fail_q;
	cnt_t   res_cnt_q;

	// Link and pair-bit memories, registered read.
	link_t  next_mem [NUM_PAGES_C];
	link_t  prev_mem [NUM_PAGES_C];
	logic   pair_mem [NUM_PAGES_C];
	link_t  nx_rd_q, pv_rd_q;
	logic   pr_rd_q;

	logic   nx_we, pv_we, pr_we;
	page_t  nx_wa, pv_wa, pr_wa, lk_ra, pr_ra;
	link_t  nx_wd, pv_wd;
	logic   pr_wd;

	// Lowest non-empty list at or above the requested order.
	logic   srch_hit;
	ord_t   srch_ord;
	always_comb begin
		srch_hit = 1'b0;
		srch_ord = '0;
		for (int c = ORDER_COUNT_C - 1; c >= 0; c--) begin
			if (ord_t'(c) >= ord_q && !head_q[c][LINK_W-1]) begin
				srch_hit = 1'b1;
				srch_ord = ord_t'(c);
			end
		end
	end

	page_t  cur_size;
	page_t  buddy;
	page_t  pair_a;
	link_t  srch_head;
	page_t  unl_n, unl_p;
	logic   unl_nv, unl_pv;
	assign cur_size  = page_t'(1) << cur_q;
	assign buddy     = pg_q ^ cur_size;
	assign pair_a    = pair_addr(cur_q, pg_q);
	assign srch_head = head_q[srch_ord];
	assign unl_nv    = !nx_rd_q[LINK_W-1];
	assign unl_pv    = !pv_rd_q[LINK_W-1];
	assign unl_n     = nx_rd_q[PAGE_W-1:0];
	assign unl_p     = pv_rd_q[PAGE_W-1:0];

	// Memory port steering per state.
	always_comb begin
		nx_we = 1'b0; nx_wa = pg_q; nx_wd = NIL_LINK;
		pv_we = 1'b0; pv_wa = pg_q; pv_wd = NIL_LINK;
		pr_we = 1'b0; pr_wa = pair_a; pr_wd = 1'b0;
		lk_ra = buddy;
		pr_ra = pair_a;
		case (state_q)
			S_CLEAR: begin
				pr_we = 1'b1;
				pr_wa = clr_q;
			end
			S_F_PAIR: begin
				pr_we = 1'b1;
				pr_wd = !pr_rd_q;
			end
			S_A_TGLW: begin
				pr_we = 1'b1;
				pr_wd = !pr_rd_q;
			end
			S_A_SRCH: lk_ra = srch_head[PAGE_W-1:0];
			S_UNL_APPLY: begin
				nx_we = unl_pv;
				nx_wa = unl_p;
				nx_wd = unl_nv ? nx_rd_q : NIL_LINK;
				pv_we = unl_nv;
				pv_wa = unl_n;
				pv_wd = unl_pv ? pv_rd_q : NIL_LINK;
			end
			S_PUSH_A: begin
				nx_we = 1'b1;
				nx_wd = head_q[cur_q][LINK_W-1] ? NIL_LINK : head_q[cur_q];
				pv_we = 1'b1;
			end
			S_PUSH_B: begin
				pv_we = !hd_q[LINK_W-1];
				pv_wa = hd_q[PAGE_W-1:0];
				pv_wd = {1'b0, pg_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (nx_we) next_mem[nx_wa] <= nx_wd;
		nx_rd_q <= next_mem[lk_ra];
	end

	always_ff @(posedge clk) begin
		if (pv_we) prev_mem[pv_wa] <= pv_wd;
		pv_rd_q <= prev_mem[lk_ra];
	end

	always_ff @(posedge clk) begin
		if (pr_we) pair_mem[pr_wa] <= pr_wd;
		pr_rd_q <= pair_mem[pr_ra];
	end

	logic [CNT_W:0] cnt_sum;
	cnt_t           req_size;
	assign cnt_sum  = {1'b0, cnt_q} + ((CNT_W+1)'(1) << block_order);
	assign req_size = cnt_t'(1) << ord_q;

	// Sequencer: state, lists, count and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			split_q     <= 1'b0;
			fail_q      <= 1'b0;
			for (int i = 0; i < ORDER_COUNT_C; i++) head_q[i] <= NIL_LINK;
		end else begin
			// raise valid when the result is registered, drop it once taken
			if (state_q == S_DONE && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					// sweep the pair bits to zero
					clr_q <= clr_q + page_t'(1);
					if (clr_q == page_t'(NUM_PAGES_C - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= op;
						ord_q   <= block_order;
						cur_q   <= block_order;
						split_q <= 1'b0;
						fail_q  <= (block_order > TOP_ORD);
						pg_q    <= page_index & ~((page_t'(1) << block_order) - page_t'(1));
						if (block_order > TOP_ORD) begin
							state_q <= S_DONE;
						end else if (op == OP_ALLOC) begin
							state_q <= S_A_SRCH;
						end else begin
							cnt_q   <= (cnt_sum > (CNT_W+1)'(MAX_CNT)) ? MAX_CNT
								: cnt_t'(cnt_sum);
							state_q <= S_F_STEP;
						end
					end
				end
				S_F_STEP: begin
					// top order never merges
					state_q <= (cur_q == TOP_ORD) ? S_PUSH_A : S_F_PAIR;
				end
				S_F_PAIR: begin
					if (!pr_rd_q) begin
						state_q <= S_PUSH_A;
					end else begin
						upg_q   <= buddy;
						state_q <= S_UNL_APPLY;
					end
				end
				S_UNL_APPLY: begin
					if (!unl_pv && head_q[cur_q] == {1'b0, upg_q})
						head_q[cur_q] <= unl_nv ? nx_rd_q : NIL_LINK;
					if (op_q != OP_ALLOC) begin
						// merge with the buddy one order up
						pg_q    <= pg_q & ~cur_size;
						cur_q   <= cur_q + ord_t'(1);
						state_q <= S_F_STEP;
					end else if (cur_q != TOP_ORD) begin
						state_q <= S_A_TGL;
					end else begin
						state_q <= (cur_q == ord_q) ? S_DONE : S_A_SPLIT;
					end
				end
				S_A_SRCH: begin
					if (!srch_hit) begin
						fail_q  <= 1'b1;
						state_q <= S_DONE;
					end else begin
						cur_q   <= srch_ord;
						pg_q    <= srch_head[PAGE_W-1:0];
						upg_q   <= srch_head[PAGE_W-1:0];
						cnt_q   <= (cnt_q >= req_size) ? cnt_q - req_size : '0;
						state_q <= S_UNL_APPLY;
					end
				end
				S_A_TGL: state_q <= S_A_TGLW;
				S_A_TGLW: begin
					// advance past the lower half just pushed
					if (split_q) pg_q <= pg_q + cur_size;
					state_q <= (cur_q == ord_q) ? S_DONE : S_A_SPLIT;
				end
				S_A_SPLIT: begin
					cur_q   <= cur_q - ord_t'(1);
					split_q <= 1'b1;
					state_q <= S_PUSH_A;
				end
				S_PUSH_A: begin
					hd_q    <= head_q[cur_q][LINK_W-1] ? NIL_LINK : head_q[cur_q];
					state_q <= S_PUSH_B;
				end
				S_PUSH_B: begin
					head_q[cur_q] <= {1'b0, pg_q};
					state_q       <= (op_q == OP_ALLOC) ? S_A_TGL : S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						res_fail_q  <= fail_q;
						res_q       <= (fail_q || op_q != OP_ALLOC) ? '0 : pg_q;
						res_cnt_q   <= cnt_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign result_page = res_q;
	assign failed      = res_fail_q;
	assign free_total  = res_cnt_q;

	`BPA_NEVER(a_cnt_max, cnt_q > MAX_CNT, "free count above page count")
	`BPA_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> state_q != S_IDLE, "idle after accept")
	`BPA_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(state_q == S_DONE), "result without done")
	`BPA_ASSERT(a_fail_zero, (out_valid && failed) |-> result_page == '0, "failed result has page")
endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import bpa_pkg::*;

	localparam int RAND_ITEMS = 1330;

	typedef struct {
		logic  op;
		ord_t  ord;
		page_t idx;
	} request_t;

	typedef struct {
		page_t page;
		logic  fail;
		cnt_t  total;
	} alloc_result_t;

	typedef struct {
		page_t page;
		ord_t  ord;
	} block_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  in_valid = 1'b0;
	logic  in_ready;
	logic  op = OP_ALLOC;
	ord_t  block_order = '0;
	page_t page_index = '0;
	logic  out_valid;
	logic  out_ready = 1'b0;
	page_t result_page;
	logic  failed;
	cnt_t  free_total;

	buddy_page_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.block_order(block_order),
		.page_index(page_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_page(result_page),
		.failed(failed),
		.free_total(free_total)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow allocator state: free lists, links, pair bits and page count.
	link_t list_top [ORDER_COUNT_C];
	link_t fwd_link [NUM_PAGES_C];
	link_t back_link [NUM_PAGES_C];
	bit    buddy_bit [ORDER_COUNT_C][NUM_PAGES_C/2];
	int    pages_free;
	// Per-page free flag, used to pick only legal frees.
	bit    page_is_free [NUM_PAGES_C];
	block_t granted_q [$];

	request_t      pending_q [$];
	alloc_result_t result_q [$];

	int  n_queued = 0;
	int  n_taken = 0;
	int  n_errors = 0;
	int  n_grants = 0;
	int  n_denied = 0;
	int  n_frees = 0;
	int  n_results = 0;
	bit  took = 0;
	bit  got = 0;
	int  send_gap = 0;
	int  recv_stall = 0;
	bit  burst = 0;

	function automatic link_t clean_link(input link_t v);
		return (v < NUM_PAGES_C) ? v : NIL_LINK;
	endfunction

	function automatic void list_insert(input int o, input int pg);
		link_t h;
		h = clean_link(list_top[o]);
		fwd_link[pg] = h;
		back_link[pg] = NIL_LINK;
		if (h != NIL_LINK)
			back_link[h] = link_t'(pg);
		list_top[o] = link_t'(pg);
	endfunction

	function automatic void list_unhook(input int o, input int pg);
		link_t n;
		link_t p;
		n = clean_link(fwd_link[pg]);
		p = clean_link(back_link[pg]);
		if (p != NIL_LINK)
			fwd_link[p] = n;
		else if (list_top[o] == link_t'(pg))
			list_top[o] = n;
		if (n != NIL_LINK)
			back_link[n] = p;
	endfunction

	// Flip the buddy bit of the pair holding pg at order o; return the old bit.
	function automatic bit flip_buddy(input int o, input int pg);
		bit old;
		old = buddy_bit[o][pg >> (o + 1)];
		buddy_bit[o][pg >> (o + 1)] = ~old;
		return old;
	endfunction

	function automatic void release_block(input int o, input int pg);
		int sz;
		sz = 1 << o;
		pg = pg & ~(sz - 1);
		for (int i = 0; i < sz; i++)
			page_is_free[pg + i] = 1;
		pages_free = pages_free + sz;
		if (pages_free > NUM_PAGES_C)
			pages_free = NUM_PAGES_C;
		// Merge upward while the buddy is free; the top order stays put.
		while (o < ORDER_COUNT_C - 1) begin
			if ((pg ^ sz) >= NUM_PAGES_C)
				break;
			if (flip_buddy(o, pg) == 0)
				break;
			list_unhook(o, pg ^ sz);
			pg = pg & ~sz;
			sz = sz << 1;
			o++;
		end
		list_insert(o, pg);
	endfunction

	function automatic bit grant_block(input int o, output int pg_out);
		int pg;
		int sz;
		int hi;
		pg_out = 0;
		for (int c = o; c < ORDER_COUNT_C; c++) begin
			pg = clean_link(list_top[c]);
			if (pg == NIL_LINK)
				continue;
			list_unhook(c, pg);
			if (c != ORDER_COUNT_C - 1)
				void'(flip_buddy(c, pg));
			sz = 1 << o;
			pages_free = (pages_free >= sz) ? pages_free - sz : 0;
			hi = c;
			sz = 1 << c;
			// Split down, leaving lower halves on the lists, keep the top part.
			while (hi > o) begin
				hi--;
				sz = sz >> 1;
				list_insert(hi, pg);
				void'(flip_buddy(hi, pg));
				pg = pg + sz;
			end
			for (int i = 0; i < (1 << o); i++)
				page_is_free[pg + i] = 0;
			pg_out = pg;
			return 1;
		end
		return 0;
	endfunction

	function automatic alloc_result_t predict_request(input request_t r);
		alloc_result_t e;
		int pg;
		e.page = '0;
		e.fail = 1'b0;
		if (r.ord >= ORDER_COUNT_C) begin
			e.fail = 1'b1;
		end else if (r.op == OP_ALLOC) begin
			if (grant_block(r.ord, pg)) begin
				e.page = page_t'(pg);
				granted_q.push_back('{page_t'(pg), r.ord});
				n_grants++;
			end else begin
				e.fail = 1'b1;
				n_denied++;
			end
		end else if (r.idx >= NUM_PAGES_C) begin
			e.fail = 1'b1;
		end else begin
			release_block(r.ord, r.idx);
			n_frees++;
		end
		e.total = cnt_t'(pages_free);
		return e;
	endfunction

	// A free is legal only when no page of the aligned block is already free.
	function automatic bit block_in_use(input int o, input int pg);
		int base;
		base = pg & ~((1 << o) - 1);
		for (int i = 0; i < (1 << o); i++)
			if (page_is_free[base + i])
				return 0;
		return 1;
	endfunction

	task automatic present(input request_t r);
		op <= r.op;
		block_order <= r.ord;
		page_index <= r.idx;
		in_valid <= 1'b1;
	endtask

	// Queue one request and hold until it is taken, so the next pick sees
	// the state it produced.
	task automatic issue(input logic o_op, input int o_ord, input int o_idx);
		pending_q.push_back('{o_op, ord_t'(o_ord), page_t'(o_idx)});
		n_queued++;
		wait (n_taken == n_queued);
	endtask

	// Accept requests and check results at the rising edge.
	always @(posedge clk) begin
		alloc_result_t e;
		if (arst_n && in_valid && in_ready) begin
			result_q.push_back(predict_request('{op, block_order, page_index}));
			n_taken++;
			took = 1;
		end
		if (arst_n && out_valid && out_ready) begin
			got = 1;
			n_results++;
			if (result_q.size() == 0) begin
				$error("result with nothing expected: page %0d failed %0b total %0d",
					result_page, failed, free_total);
				n_errors++;
			end else begin
				e = result_q.pop_front();
				if (result_page !== e.page) begin
					$error("result_page expected %0d actual %0d", e.page, result_page);
					n_errors++;
				end
				if (failed !== e.fail) begin
					$error("failed expected %0b actual %0b", e.fail, failed);
					n_errors++;
				end
				if (free_total !== e.total) begin
					$error("free_total expected %0d actual %0d", e.total, free_total);
					n_errors++;
				end
			end
		end
	end

	// Request driver: hold valid until taken, then wait a random gap.
	always @(negedge clk) begin
		if (took) begin
			took = 0;
			send_gap = burst ? 0 : $urandom_range(0, 9);
			if (send_gap == 0 && pending_q.size() != 0)
				present(pending_q.pop_front());
			else
				in_valid <= 1'b0;
		end else if (!in_valid) begin
			if (send_gap > 0)
				send_gap--;
			else if (pending_q.size() != 0)
				present(pending_q.pop_front());
		end
	end

	// Result side: stall a random number of cycles before each result.
	always @(negedge clk) begin
		if (got) begin
			got = 0;
			recv_stall = burst ? 0 : $urandom_range(0, 9);
			out_ready <= (recv_stall == 0);
		end else if (!out_ready) begin
			if (recv_stall == 0)
				out_ready <= 1'b1;
			else
				recv_stall--;
		end
	end

	initial begin
		block_t b;
		int     k;
		int     o;
		int     pg;
		int     sel;
		bit     done;
		for (int i = 0; i < ORDER_COUNT_C; i++)
			list_top[i] = NIL_LINK;
		foreach (fwd_link[i]) begin
			fwd_link[i] = '0;
			back_link[i] = '0;
			page_is_free[i] = 0;
		end
		foreach (buddy_bit[i, j])
			buddy_bit[i][j] = 0;
		pages_free = 0;
		recv_stall = $urandom_range(0, 9);

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Directed: empty allocator, oversized orders, misaligned frees,
		// full merge up to the top order, and the extreme pages.
		issue(OP_ALLOC, 0, 12'hFFF);
		issue(OP_ALLOC, 10, 0);
		issue(OP_ALLOC, 15, 0);
		issue(OP_FREE, 11, 5);
		issue(OP_FREE, 15, 12'hFFF);
		issue(OP_FREE, 10, 12'h3FF);
		issue(OP_ALLOC, 0, 0);
		issue(OP_FREE, 0, 12'h3FF);
		issue(OP_ALLOC, 10, 12'hAAA);
		issue(OP_FREE, 0, 12'hFFF);
		issue(OP_FREE, 0, 12'hFFE);
		issue(OP_FREE, 1, 12'hFFD);
		issue(OP_ALLOC, 3, 12'h555);
		issue(OP_ALLOC, 0, 0);
		issue(OP_FREE, 10, 12'h000);
		issue(OP_FREE, 10, 12'h800);
		issue(OP_ALLOC, 1, 0);
		issue(OP_ALLOC, 11, 0);
		issue(OP_FREE, 9, 12'hC01);

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 60 == 0)
				burst = ($urandom_range(0, 3) == 0);
			// Drain once mid-run so the block goes fully idle.
			if (n == RAND_ITEMS / 2)
				wait (result_q.size() == 0);
			sel = $urandom_range(0, 99);
			if (sel < 4) begin
				issue($urandom_range(0, 1), $urandom_range(11, 15), $urandom_range(0, 4095));
				continue;
			end
			if (sel < 42) begin
				o = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : $urandom_range(0, 3);
				issue(OP_ALLOC, o, $urandom_range(0, 4095));
				continue;
			end
			done = 0;
			// Return a granted block, sometimes with a misaligned index.
			if (sel < 75 && granted_q.size() != 0) begin
				k = $urandom_range(0, granted_q.size() - 1);
				b = granted_q[k];
				granted_q.delete(k);
				if (block_in_use(b.ord, b.page)) begin
					issue(OP_FREE, b.ord, b.page + $urandom_range(0, (1 << b.ord) - 1));
					done = 1;
				end
			end
			// Otherwise free any block that holds no free page.
			for (int t = 0; t < 8 && !done; t++) begin
				o = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 10) : $urandom_range(0, 2);
				pg = $urandom_range(0, 4095);
				if (block_in_use(o, pg)) begin
					issue(OP_FREE, o, pg);
					done = 1;
				end
			end
			if (!done)
				issue(OP_ALLOC, $urandom_range(0, 4), $urandom_range(0, 4095));
		end

		wait (result_q.size() == 0 && pending_q.size() == 0);
		repeat (100) @(posedge clk);
		$display("Covered %0d requests: %0d grants, %0d denied allocates, %0d frees.",
			n_taken, n_grants, n_denied, n_frees);
		$display("Results checked: %0d, field errors: %0d.", n_results, n_errors);
		if (n_errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/bpa_pkg.sv
rtl/core/buddy_page_allocator.sv
test/tb_top.sv
